FILE: rtl/note_step_sequencer_core_assert.svh
// Assertion macros shared by the note step sequencer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef NOTE_STEP_SEQUENCER_CORE_ASSERT_SVH
`define NOTE_STEP_SEQUENCER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define NSS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define NSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/nss_pkg.sv
// Package of the note step sequencer: codes, result types and defaults.
// Depends on nothing; used by the RTL modules and the testbench.
package nss_pkg;

  // Default depth of the note memory.
  localparam int unsigned MemDepthDef = 255;

  // Command codes of the input channel.
  typedef enum logic [1:0] {
    CMD_MODE  = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  // Sequencer modes.
  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_REC  = 2'd2
  } mode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ON  = 2'd0,
    KIND_OFF = 2'd1,
    KIND_ALL = 2'd2
  } kind_e;

  // Special event codes; non-negative codes are notes.
  localparam logic signed [7:0] EvSilence = -8'sd1;
  localparam logic signed [7:0] EvTie     = -8'sd2;
  localparam logic signed [7:0] EvBack    = -8'sd3;

  // One result transaction.
  typedef struct packed {
    kind_e      kind;
    logic [6:0] note_number;
    logic       last;
  } res_t;

  // Results of one processed item, handed to the output buffer.
  typedef struct packed {
    logic       load;
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } res_load_t;

endpackage

FILE: rtl/nss_if.sv
// Channel interfaces of the note step sequencer: command input and result output.
// Depends on nothing; used by the control, output buffer and top level.
interface nss_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic [1:0]        target_mode;
  logic signed [7:0] event_code;

  modport source (output valid, command, target_mode, event_code, input ready);
  modport sink   (input valid, command, target_mode, event_code, output ready);
endinterface

interface nss_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] note_number;
  logic       last;

  modport source (output valid, kind, note_number, last, input ready);
  modport sink   (input valid, kind, note_number, last, output ready);
endinterface

FILE: rtl/nss_note_mem.sv
// Note memory: one write port and two registered read ports.
// Depends on nss_pkg for the default depth.
module nss_note_mem #(
  parameter int unsigned MEM_DEPTH = nss_pkg::MemDepthDef,
  parameter int unsigned AW        = $clog2(MEM_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic signed [7:0]    wr_data_i,
  input  logic [AW-1:0]        rd_cur_addr_i,
  input  logic [AW-1:0]        rd_prev_addr_i,
  output logic signed [7:0]    rd_cur_o,
  output logic signed [7:0]    rd_prev_o
);

  logic signed [7:0] mem_q [MEM_DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read ports, data registered.
  always_ff @(posedge clk_i) begin
    rd_cur_o  <= mem_q[rd_cur_addr_i];
    rd_prev_o <= mem_q[rd_prev_addr_i];
  end

endmodule

FILE: rtl/nss_ctrl.sv
// Sequencer control: input register, mode and step state, and result decode.
// Depends on nss_pkg, nss_if and the assertion macro header.
`include "note_step_sequencer_core_assert.svh"

module nss_ctrl #(
  parameter int unsigned MEM_DEPTH = nss_pkg::MemDepthDef,
  parameter int unsigned AW        = $clog2(MEM_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  nss_cmd_if.sink             cmd_i,
  input  logic signed [7:0]   rd_cur_i,
  input  logic signed [7:0]   rd_prev_i,
  output logic [AW-1:0]       rd_cur_addr_o,
  output logic [AW-1:0]       rd_prev_addr_o,
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output logic signed [7:0]   wr_data_o,
  input  logic                buf_empty_i,
  output nss_pkg::res_load_t  load_o
);
  import nss_pkg::*;

  localparam logic [AW-1:0] LastStep = AW'(MEM_DEPTH - 1);

  logic              busy_q, busy_d;
  logic [1:0]        cmd_q;
  logic [1:0]        tgt_q;
  logic signed [7:0] ev_q;
  mode_e             mode_q, mode_d;
  logic [AW-1:0]     step_q, step_d;
  logic [AW-1:0]     play_len_q, play_len_d;
  logic [AW-1:0]     stored_len_q, stored_len_d;
  logic              accept;
  logic              proc;
  logic              prev_note;
  logic signed [7:0] prev;

  assign cmd_i.ready = !busy_q;
  assign accept      = cmd_i.valid && cmd_i.ready;
  // An item is processed once the output buffer has room for all its results.
  assign proc        = busy_q && buf_empty_i;

  // Memory reads always follow the current step; the read data is registered.
  assign rd_cur_addr_o  = step_q;
  assign rd_prev_addr_o = (step_q == '0) ? '0 : step_q - AW'(1);

  // Previous entry counts as silence at the first step.
  assign prev      = (step_q == '0) ? EvSilence : rd_prev_i;
  assign prev_note = !prev[7];

  // Input register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i.command;
      tgt_q <= cmd_i.target_mode;
      ev_q  <= cmd_i.event_code;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      mode_q       <= MODE_STOP;
      step_q       <= '0;
      play_len_q   <= '0;
      stored_len_q <= '0;
    end else begin
      busy_q       <= busy_d;
      mode_q       <= mode_d;
      step_q       <= step_d;
      play_len_q   <= play_len_d;
      stored_len_q <= stored_len_d;
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (proc) begin
      busy_d = 1'b0;
    end
  end

  // State update and memory write for the item being processed.
  always_comb begin
    mode_d       = mode_q;
    step_d       = step_q;
    play_len_d   = play_len_q;
    stored_len_d = stored_len_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = step_q;
    wr_data_o    = ev_q;
    if (proc) begin
      case (cmd_q)
        CMD_MODE: begin
          case (tgt_q)
            MODE_STOP: begin
              step_d = '0;
              mode_d = MODE_STOP;
            end
            MODE_PLAY: begin
              step_d     = '0;
              play_len_d = stored_len_q;
              mode_d     = MODE_PLAY;
            end
            MODE_REC: begin
              step_d       = '0;
              stored_len_d = '0;
              mode_d       = MODE_REC;
            end
            default: ;
          endcase
        end
        CMD_EVENT: begin
          if (mode_q == MODE_REC) begin
            if (ev_q == EvBack) begin
              step_d = (step_q == '0) ? '0 : step_q - AW'(1);
            end else begin
              wr_en_o = 1'b1;
              step_d  = (step_q == LastStep) ? LastStep : step_q + AW'(1);
            end
            stored_len_d = step_d;
          end
        end
        CMD_TICK: begin
          if (mode_q == MODE_PLAY && play_len_q != '0) begin
            step_d = (step_q + AW'(1) == play_len_q) ? '0 : step_q + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Results of the item being processed.
  always_comb begin
    load_o                    = '0;
    load_o.load               = proc;
    load_o.first.kind         = KIND_ALL;
    load_o.second.kind        = KIND_OFF;
    load_o.second.note_number = prev[6:0];
    load_o.second.last        = 1'b1;
    case (cmd_q)
      CMD_MODE: begin
        if (tgt_q == MODE_STOP) begin
          load_o.count      = 2'd1;
          load_o.first.kind = KIND_ALL;
          load_o.first.last = 1'b1;
        end
      end
      CMD_TICK: begin
        if (mode_q == MODE_PLAY && play_len_q != '0) begin
          if (rd_cur_i == EvSilence) begin
            // Silence releases the previous note, if any.
            load_o.first.kind        = KIND_OFF;
            load_o.first.note_number = prev[6:0];
            load_o.first.last        = 1'b1;
            load_o.count             = prev_note ? 2'd1 : 2'd0;
          end else if (!rd_cur_i[7]) begin
            // A note starts, then the previous note is released.
            load_o.first.kind        = KIND_ON;
            load_o.first.note_number = rd_cur_i[6:0];
            load_o.first.last        = !prev_note;
            load_o.count             = prev_note ? 2'd2 : 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  `NSS_ASSERT(a_step_in_range, clk_i, rst_ni, step_q <= LastStep, "step beyond memory")
  `NSS_ASSERT(a_play_step, clk_i, rst_ni, (mode_q == MODE_PLAY && play_len_q != '0) |-> step_q < play_len_q, "play step beyond length")
  `NSS_ASSERT(a_rec_length, clk_i, rst_ni, (mode_q == MODE_REC) |-> stored_len_q == step_q, "recorded length differs from step")
  `NSS_ASSERT(a_proc_done, clk_i, rst_ni, (proc && !accept) |=> !busy_q, "item processed twice")

endmodule

FILE: rtl/nss_out_buf.sv
// Two-entry output buffer that holds the results of one item until taken.
// Depends on nss_pkg and nss_if.
module nss_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nss_pkg::res_load_t load_i,
  output logic               empty_o,
  nss_res_if.source          res_o
);
  import nss_pkg::*;

  res_t       ent_q [2];
  logic [1:0] cnt_q;
  logic       pop;

  assign empty_o = (cnt_q == 2'd0);
  assign pop     = res_o.valid && res_o.ready;

  // Head entry drives the result channel.
  assign res_o.valid       = !empty_o;
  assign res_o.kind        = ent_q[0].kind;
  assign res_o.note_number = ent_q[0].note_number;
  assign res_o.last        = ent_q[0].last;

  // Fill count; loads only arrive when the buffer is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i.load) begin
      cnt_q <= load_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (load_i.load) begin
      ent_q[0] <= load_i.first;
      ent_q[1] <= load_i.second;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
    end
  end

endmodule

FILE: rtl/note_step_sequencer_core.sv
// Top level of the note step sequencer: control, note memory and output buffer.
// Depends on nss_pkg, nss_if, nss_note_mem, nss_ctrl and nss_out_buf.
//
//   Channel  Direction  Carries
//   cmd_i    in         command, target_mode, event_code
//   res_o    out        kind, note_number, last (up to two per command)
//
// A command is taken into the input register and then processed against the note
// memory read data registered from the current step; its results are registered
// in the output buffer.
// A command is processed only once the two-entry output buffer is empty, so a
// stalled result channel holds the command in the input register.
// Reset clears mode, step and lengths; the note memory is not cleared.
module note_step_sequencer_core #(
  parameter int unsigned MEM_DEPTH = nss_pkg::MemDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nss_cmd_if.sink    cmd_i,
  nss_res_if.source  res_o
);
  import nss_pkg::*;

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic signed [7:0] wr_data;
  logic [AW-1:0]     rd_cur_addr;
  logic [AW-1:0]     rd_prev_addr;
  logic signed [7:0] rd_cur;
  logic signed [7:0] rd_prev;
  logic              buf_empty;
  res_load_t         load;

  nss_ctrl #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .rd_cur_i       (rd_cur),
    .rd_prev_i      (rd_prev),
    .rd_cur_addr_o  (rd_cur_addr),
    .rd_prev_addr_o (rd_prev_addr),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .buf_empty_i    (buf_empty),
    .load_o         (load)
  );

  nss_note_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_mem (
    .clk_i          (clk_i),
    .wr_en_i        (wr_en),
    .wr_addr_i      (wr_addr),
    .wr_data_i      (wr_data),
    .rd_cur_addr_i  (rd_cur_addr),
    .rd_prev_addr_i (rd_prev_addr),
    .rd_cur_o       (rd_cur),
    .rd_prev_o      (rd_prev)
  );

  nss_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .empty_o (buf_empty),
    .res_o   (res_o)
  );

endmodule

FILE: test/tb.sv
// Self-checking testbench of note_step_sequencer_core: directed cues, then random sessions.
// Depends on nss_pkg, nss_if and the sequencer RTL; results are checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nss_pkg::*;

  localparam int unsigned MemDepth      = MemDepthDef;
  localparam int          TargetItems   = 1900;
  localparam int          WatchdogLimit = 2000;
  localparam int          HoldCycles    = 150;
  localparam int          DrainCycles   = 20;

  // Codes that the block must ignore.
  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam res_t NoRes = '{KIND_ON, 7'd0, 1'b0};

  // One directed cue; expected results are filled in only where typed is set.
  typedef struct packed {
    logic [1:0] c;
    logic [1:0] tgt;
    logic [7:0] ev;
    logic       typed;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } cue_t;

  localparam int NumCues = 25;
  localparam cue_t Cues [NumCues] = '{
    // Nothing happens before a mode is set, apart from stop itself.
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  8'd60,     1'b1, 2'd0, NoRes, NoRes},
    '{CMD_MODE,  MODE_STOP,  8'd0,      1'b1, 2'd1, '{KIND_ALL, 7'd0, 1'b1}, NoRes},
    '{CmdUnused, ModeUnused, 8'hff,     1'b1, 2'd0, NoRes, NoRes},
    '{CMD_MODE,  ModeUnused, 8'd0,      1'b1, 2'd0, NoRes, NoRes},
    // Record a short pattern that holds every kind of entry.
    '{CMD_MODE,  MODE_REC,   8'd0,      1'b1, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  EvBack,    1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  8'd0,      1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  8'd127,    1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  EvSilence, 1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  EvTie,     1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  8'h80,     1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  8'd60,     1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  EvBack,    1'b0, 2'd0, NoRes, NoRes},
    '{CMD_EVENT, MODE_STOP,  8'd5,      1'b0, 2'd0, NoRes, NoRes},
    // Play it back: note 0, 127, silence, tie, -128, note 5, then wrap.
    '{CMD_MODE,  MODE_PLAY,  8'd0,      1'b1, 2'd0, NoRes, NoRes},
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd1, '{KIND_ON, 7'd0, 1'b1}, NoRes},
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd2,
      '{KIND_ON, 7'd127, 1'b0}, '{KIND_OFF, 7'd0, 1'b1}},
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd1, '{KIND_OFF, 7'd127, 1'b1}, NoRes},
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd0, NoRes, NoRes},
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd0, NoRes, NoRes},
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd1, '{KIND_ON, 7'd5, 1'b1}, NoRes},
    '{CMD_TICK,  MODE_STOP,  8'd0,      1'b1, 2'd1, '{KIND_ON, 7'd0, 1'b1}, NoRes},
    '{CMD_EVENT, MODE_STOP,  8'd33,     1'b1, 2'd0, NoRes, NoRes},
    '{CMD_MODE,  MODE_STOP,  8'd0,      1'b1, 2'd1, '{KIND_ALL, 7'd0, 1'b1}, NoRes}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  nss_cmd_if cmd_if ();
  nss_res_if res_if ();

  note_step_sequencer_core #(
    .MEM_DEPTH(MemDepth)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sequencer state as the predictor sees it.
  mode_e             seq_mode;
  logic [7:0]        seq_pos;
  logic [7:0]        seq_play_len;
  logic [7:0]        seq_stored_len;
  logic signed [7:0] seq_mem [MemDepth];
  res_t              seq_out [2];
  bit                seq_acted;

  res_t note_events_due [$];
  int   mismatches   = 0;
  int   acted_items  = 0;
  int   notes_seen   = 0;
  int   idle_cycles  = 0;
  bit   send_steady  = 1'b0;
  bit   take_steady  = 1'b0;

  // Advances the sequencer by one command; returns how many results it causes.
  function automatic int sequencer_advance(logic [1:0] c, logic [1:0] tgt,
                                           logic signed [7:0] ev);
    logic signed [7:0] cur;
    logic signed [7:0] prv;
    int                n;
    n         = 0;
    seq_acted = 1'b0;
    case (c)
      CMD_MODE: begin
        if (tgt != ModeUnused) begin
          seq_acted = 1'b1;
          seq_pos   = '0;
          if (tgt == MODE_REC) seq_stored_len = '0;
          if (tgt == MODE_PLAY) seq_play_len = seq_stored_len;
          if (tgt == MODE_STOP) begin
            seq_out[0] = '{KIND_ALL, 7'd0, 1'b0};
            n = 1;
          end
          seq_mode = mode_e'(tgt);
        end
      end
      CMD_EVENT: begin
        if (seq_mode == MODE_REC) begin
          seq_acted = 1'b1;
          if (ev == EvBack) begin
            if (seq_pos > 0) seq_pos = seq_pos - 8'd1;
          end else begin
            seq_mem[seq_pos] = ev;
            if (int'(seq_pos) < int'(MemDepth) - 1) seq_pos = seq_pos + 8'd1;
          end
          seq_stored_len = seq_pos;
        end
      end
      CMD_TICK: begin
        if (seq_mode == MODE_PLAY && seq_play_len != 0) begin
          seq_acted = 1'b1;
          cur = seq_mem[seq_pos];
          prv = (seq_pos > 0) ? seq_mem[seq_pos - 8'd1] : EvSilence;
          // A silence releases the previous note; a note starts before the release.
          if (cur == EvSilence) begin
            if (prv >= 0) begin
              seq_out[n] = '{KIND_OFF, prv[6:0], 1'b0};
              n++;
            end
          end else if (cur >= 0) begin
            seq_out[n] = '{KIND_ON, cur[6:0], 1'b0};
            n++;
            if (prv >= 0) begin
              seq_out[n] = '{KIND_OFF, prv[6:0], 1'b0};
              n++;
            end
          end
          seq_pos = 8'((int'(seq_pos) + 1) % int'(seq_play_len));
        end
      end
      default: ;
    endcase
    if (n > 0) seq_out[n - 1].last = 1'b1;
    return n;
  endfunction

  // Picks a record event: mostly notes, then the special codes and odd negatives.
  function automatic logic [7:0] pick_event();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 8'($urandom_range(0, 127));
    if (sel < 75) return EvSilence;
    if (sel < 85) return EvTie;
    if (sel < 95) return EvBack;
    return 8'($urandom_range(128, 252));
  endfunction

  // Offers one command transaction; called and left at a falling edge.
  task automatic issue(input logic [1:0] c, input logic [1:0] tgt, input logic [7:0] ev,
                       input bit typed = 1'b0, input int n = 0,
                       input res_t r0 = '0, input res_t r1 = '0);
    int gap;
    int cnt;
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= c;
    cmd_if.target_mode <= tgt;
    cmd_if.event_code  <= ev;
    do @(posedge clk_i); while (!cmd_if.ready);
    cnt = sequencer_advance(c, tgt, ev);
    if (typed) begin
      if (n > 0) note_events_due.push_back(r0);
      if (n > 1) note_events_due.push_back(r1);
    end else begin
      for (int i = 0; i < cnt; i++) note_events_due.push_back(seq_out[i]);
    end
    if (seq_acted) acted_items++;
    @(negedge clk_i);
  endtask

  // Stimulus: reset, directed cues, then record and play sessions with noise.
  initial begin
    int sess;
    int nrec;
    bit long_rec;
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CMD_MODE;
    cmd_if.target_mode = MODE_STOP;
    cmd_if.event_code  = '0;
    seq_mode           = MODE_STOP;
    seq_pos            = '0;
    seq_play_len       = '0;
    seq_stored_len     = '0;
    sess               = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumCues; i++) begin
      issue(Cues[i].c, Cues[i].tgt, Cues[i].ev, Cues[i].typed, Cues[i].n,
            Cues[i].r0, Cues[i].r1);
    end

    while (acted_items < TargetItems) begin
      // Record a pattern; the first session and every 32nd one run into saturation
      // at the last step, with no stray commands that could cut them short.
      issue(CMD_MODE, MODE_REC, 8'($urandom));
      long_rec = (sess % 32 == 0);
      nrec = long_rec ? $urandom_range(380, 400) : $urandom_range(1, 12);
      repeat (nrec) begin
        if (!long_rec && $urandom_range(0, 9) == 0)
          issue(2'($urandom), 2'($urandom), 8'($urandom));
        issue(CMD_EVENT, 2'($urandom), pick_event());
      end
      // Play it for a while, with stray commands mixed in.
      issue(CMD_MODE, MODE_PLAY, 8'($urandom));
      repeat ($urandom_range(1, 30)) begin
        if ($urandom_range(0, 9) == 0)
          issue(2'($urandom), 2'($urandom), 8'($urandom));
        issue(CMD_TICK, 2'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 2) == 0) issue(CMD_MODE, MODE_STOP, 8'($urandom));
      sess++;
    end
    cmd_if.valid <= 1'b0;

    while (note_events_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random stalls, steady stretches and two long hold-offs.
  initial begin
    res_t exp_res;
    int   gap;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
      gap = take_steady ? 0 : $urandom_range(0, 11);
      if (notes_seen == 150 || notes_seen == 500) gap = HoldCycles;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      notes_seen++;
      if (note_events_due.size() == 0) begin
        $display("%0t: unexpected result kind %0d note %0d last %0d", $time,
                 res_if.kind, res_if.note_number, res_if.last);
        mismatches++;
      end else begin
        exp_res = note_events_due.pop_front();
        if (res_if.kind !== exp_res.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_res.kind, res_if.kind);
          mismatches++;
        end
        if (res_if.note_number !== exp_res.note_number) begin
          $display("%0t: note_number expected %0d actual %0d", $time,
                   exp_res.note_number, res_if.note_number);
          mismatches++;
        end
        if (res_if.last !== exp_res.last) begin
          $display("%0t: last expected %0d actual %0d", $time, exp_res.last, res_if.last);
          mismatches++;
        end
      end
      @(negedge clk_i);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
